FILE: hw/rtl/dbgd_pkg.sv
package dbgd_pkg;

	localparam int NUM_PIXELS = 16;

	localparam int DIST_W  = 16;
	localparam int PIX_W   = 6;
	localparam int LIT_W   = PIX_W + 1;
	localparam int NUM_W   = DIST_W + PIX_W;
	localparam int STEP_W  = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(NUM_PIXELS - 1);
	localparam logic [LIT_W-1:0] ALL_LIT  = LIT_W'(NUM_PIXELS);

	// register indexes
	localparam logic [1:0] REG_MAX    = 2'd0;
	localparam logic [1:0] REG_STOP   = 2'd1;
	localparam logic [1:0] REG_ORANGE = 2'd2;
	localparam logic [1:0] REG_RED    = 2'd3;

	localparam logic [DIST_W-1:0] MAX_RST    = 16'd2000;
	localparam logic [DIST_W-1:0] STOP_RST   = 16'd300;
	localparam logic [DIST_W-1:0] ORANGE_RST = 16'd1000;
	localparam logic [DIST_W-1:0] RED_RST    = 16'd600;

	localparam logic [7:0] COL_FULL = 8'd255;
	localparam logic [7:0] COL_HALF = 8'd128;
	localparam logic [7:0] COL_OFF  = 8'd0;

	typedef struct packed {
		logic [DIST_W-1:0] max_distance;
		logic [DIST_W-1:0] stop_distance;
		logic [DIST_W-1:0] orange_distance;
		logic [DIST_W-1:0] red_distance;
	} dbgd_cfg_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic emit_adv;
	} dbgd_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic last_pix;
	} dbgd_sts_t;

endpackage

FILE: hw/rtl/dbgd_regs.sv
module dbgd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dbgd_pkg::ADDR_W-1:0]  paddr,
	input  logic [dbgd_pkg::DATA_W-1:0]  pwdata,
	output logic [dbgd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output dbgd_pkg::dbgd_cfg_t          cfg
);
	import dbgd_pkg::*;

	dbgd_cfg_t   cfg_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_distance    <= MAX_RST;
			cfg_q.stop_distance   <= STOP_RST;
			cfg_q.orange_distance <= ORANGE_RST;
			cfg_q.red_distance    <= RED_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX:    cfg_q.max_distance    <= pwdata[DIST_W-1:0];
				REG_STOP:   cfg_q.stop_distance   <= pwdata[DIST_W-1:0];
				REG_ORANGE: cfg_q.orange_distance <= pwdata[DIST_W-1:0];
				REG_RED:    cfg_q.red_distance    <= pwdata[DIST_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX:    prdata = DATA_W'(cfg_q.max_distance);
			REG_STOP:   prdata = DATA_W'(cfg_q.stop_distance);
			REG_ORANGE: prdata = DATA_W'(cfg_q.orange_distance);
			REG_RED:    prdata = DATA_W'(cfg_q.red_distance);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/dbgd_ctrl.sv
module dbgd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_stall,
	input  dbgd_pkg::dbgd_sts_t  sts,
	output dbgd_pkg::dbgd_cmd_t  cmd,
	output logic                 busy,
	output logic                 emitting
);
	import dbgd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SETUP = 4'b0010,
		S_DIV   = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign busy     = (state_q != S_IDLE);
	assign emitting = (state_q == S_EMIT);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.setup    = (state_q == S_SETUP);
		cmd.div_step = (state_q == S_DIV);
		cmd.emit_adv = (state_q == S_EMIT) && !out_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_SETUP;
			S_SETUP: state_d = sts.need_div ? S_DIV : S_EMIT;
			S_DIV:   if (sts.div_last) state_d = S_EMIT;
			S_EMIT:  if (!out_stall && sts.last_pix) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/dbgd_datapath.sv
module dbgd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dbgd_pkg::dbgd_cmd_t           cmd,
	input  dbgd_pkg::dbgd_cfg_t           cfg,
	input  logic [dbgd_pkg::DIST_W-1:0]   distance_mm,
	output dbgd_pkg::dbgd_sts_t           sts,
	output logic [dbgd_pkg::PIX_W-1:0]    pixel_index,
	output logic [7:0]                    pixel_red,
	output logic [7:0]                    pixel_green,
	output logic [7:0]                    pixel_blue,
	output logic                          last_pixel
);
	import dbgd_pkg::*;

	logic [DIST_W-1:0] dist_q;
	logic              flash_phase_q;
	logic [7:0]        col_r_q, col_g_q;
	logic [LIT_W-1:0]  lit_q;
	logic [NUM_W-1:0]  rem_q, dsh_q;
	logic [STEP_W-1:0] step_q;
	logic [PIX_W-1:0]  idx_q;

	logic              is_flash, in_bar, ge;
	logic [DIST_W-1:0] span, den;
	logic [NUM_W-1:0]  num;
	logic [7:0]        bar_r, bar_g;
	logic              pix_on;

	assign is_flash = dist_q <= cfg.stop_distance;
	assign in_bar   = !is_flash && (dist_q < cfg.max_distance);
	assign span     = cfg.max_distance - dist_q;
	assign den      = cfg.max_distance - cfg.stop_distance;
	assign num      = NUM_W'(span) * NUM_W'(NUM_PIXELS);
	assign ge       = rem_q >= dsh_q;

	always_comb begin
		priority if (dist_q <= cfg.red_distance) begin
			bar_r = COL_FULL;
			bar_g = COL_OFF;
		end else if (dist_q <= cfg.orange_distance) begin
			bar_r = COL_FULL;
			bar_g = COL_HALF;
		end else begin
			bar_r = COL_OFF;
			bar_g = COL_FULL;
		end
	end

	assign sts.need_div = in_bar;
	assign sts.div_last = step_q == STEP_W'(PIX_W - 1);
	assign sts.last_pix = idx_q == LAST_IDX;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q <= distance_mm;
		end
		// span < den, so the quotient stays below NUM_PIXELS: no clamp needed
		if (cmd.setup) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'(den) << (PIX_W - 1);
			step_q <= '0;
			if (is_flash) begin
				col_r_q <= flash_phase_q ? COL_FULL : COL_OFF;
				col_g_q <= COL_OFF;
				lit_q   <= ALL_LIT;
			end else begin
				col_r_q <= bar_r;
				col_g_q <= bar_g;
				lit_q   <= '0;
			end
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			lit_q  <= {lit_q[LIT_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_phase_q <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (cmd.setup) begin
				flash_phase_q <= is_flash ? !flash_phase_q : 1'b0;
			end
			if (cmd.emit_adv) begin
				idx_q <= sts.last_pix ? '0 : idx_q + PIX_W'(1);
			end
		end
	end

	assign pix_on      = LIT_W'(idx_q) < lit_q;
	assign pixel_index = idx_q;
	assign pixel_red   = pix_on ? col_r_q : COL_OFF;
	assign pixel_green = pix_on ? col_g_q : COL_OFF;
	assign pixel_blue  = COL_OFF;
	assign last_pixel  = sts.last_pix;

endmodule

FILE: hw/rtl/distance_bar_graph_driver.sv
// Distance bar graph driver: turns one distance sample (mm) into one frame of
// NUM_PIXELS pixel colors for an LED strip.
// Input channel: in_valid/in_stall with distance_mm. in_stall is high from
// the acceptance of a sample until its last pixel has been taken, so one
// sample is worked on at a time.
// Output channel: out_valid/out_stall with pixel_index, pixel_red/green/blue
// and last_pixel; pixels come in order from 0, last_pixel marks the final one.
// Sequence: a setup state after acceptance, then, for a bar frame with a
// distance between the stop and max thresholds, the restoring divider that
// computes the lit count, then one pixel per cycle while out_stall is low.
// Other frames go straight from setup to the pixels, with no division.
// Output stall holds the current pixel and extends the frame while it is high.
// Reset clears the controller, the pixel counter and the flash phase, and
// loads the threshold registers with their defaults. The user must write
// them over the APB port only while the block is idle; it is not enforced.
module distance_bar_graph_driver (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dbgd_pkg::ADDR_W-1:0]  paddr,
	input  logic [dbgd_pkg::DATA_W-1:0]  pwdata,
	output logic [dbgd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dbgd_pkg::DIST_W-1:0]  distance_mm,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dbgd_pkg::PIX_W-1:0]   pixel_index,
	output logic [7:0]                   pixel_red,
	output logic [7:0]                   pixel_green,
	output logic [7:0]                   pixel_blue,
	output logic                         last_pixel
);
	import dbgd_pkg::*;

	dbgd_cfg_t cfg;
	dbgd_cmd_t cmd;
	dbgd_sts_t sts;
	logic      busy, emitting;

	dbgd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.emitting  (emitting)
	);

	dbgd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.distance_mm (distance_mm),
		.sts         (sts),
		.pixel_index (pixel_index),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.last_pixel  (last_pixel)
	);

	assign in_stall  = busy;
	assign out_valid = emitting;

	// no pixel goes out while a new sample can be taken
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("output valid while input side is open");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("sample accepted but block not busy in setup");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_pixel |=> !in_stall && pixel_index == '0)
		else $error("frame end did not return the block to idle");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_index == LAST_IDX)
		else $error("last pixel flag on wrong index");

endmodule

FILE: tb/distance_bar_graph_driver_tb.sv
module distance_bar_graph_driver_tb;
	import dbgd_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] idx;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} pixel_t;

	// typed rows carry the lit count and bar red level read straight off the rules
	typedef struct packed {
		logic [DIST_W-1:0] mm;
		bit                typed;
		int                lit;
		logic [7:0]        red;
	} sample_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [DIST_W-1:0]   distance_mm = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PIX_W-1:0]    pixel_index;
	logic [7:0]          pixel_red;
	logic [7:0]          pixel_green;
	logic [7:0]          pixel_blue;
	logic                last_pixel;

	logic [DIST_W-1:0]   cfg_max = MAX_RST;
	logic [DIST_W-1:0]   cfg_stop = STOP_RST;
	logic [DIST_W-1:0]   cfg_orange = ORANGE_RST;
	logic [DIST_W-1:0]   cfg_red = RED_RST;
	logic                flash_on = 1'b0;

	pixel_t              expected_pixels[$];
	pixel_t              seen_pixel;
	pixel_t              want_pixel;
	int                  mismatch_count = 0;
	int                  in_idle_pct = 0;
	int                  out_stall_pct = 0;

	sample_row_t directed_rows[18] = '{
		'{16'd0,     1'b1, 16, COL_OFF},
		'{16'd300,   1'b1, 16, COL_FULL},
		'{16'd65535, 1'b1, 0,  COL_OFF},
		'{16'd2000,  1'b1, 0,  COL_OFF},
		'{16'd301,   1'b1, 15, COL_FULL},
		'{16'd1999,  1'b1, 0,  COL_OFF},
		'{16'd600,   1'b0, 0,  COL_OFF},
		'{16'd601,   1'b0, 0,  COL_OFF},
		'{16'd1000,  1'b0, 0,  COL_OFF},
		'{16'd1001,  1'b0, 0,  COL_OFF},
		'{16'd0,     1'b1, 16, COL_OFF},
		'{16'd100,   1'b1, 16, COL_FULL},
		'{16'd200,   1'b1, 16, COL_OFF},
		'{16'd1500,  1'b0, 0,  COL_OFF},
		'{16'h5555,  1'b1, 0,  COL_OFF},
		'{16'hAAAA,  1'b1, 0,  COL_OFF},
		'{16'd299,   1'b0, 0,  COL_OFF},
		'{16'd1,     1'b0, 0,  COL_OFF}
	};

	distance_bar_graph_driver uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.distance_mm (distance_mm),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.last_pixel  (last_pixel)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#6000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// lit count and bar color of one frame; advances the flash phase on a flash frame and clears it otherwise
	function automatic void predict_frame(input logic [DIST_W-1:0] d, output int lit,
			output logic [7:0] r, output logic [7:0] g);
		longint num;
		longint den;
		if (d <= cfg_stop) begin
			lit = NUM_PIXELS;
			r = flash_on ? COL_FULL : COL_OFF;
			g = COL_OFF;
			flash_on = ~flash_on;
		end else begin
			lit = 0;
			if (d < cfg_max) begin
				num = (longint'(cfg_max) - longint'(d)) * NUM_PIXELS;
				den = longint'(cfg_max) - longint'(cfg_stop);
				lit = int'(num / den);
			end
			if (lit > NUM_PIXELS)
				lit = NUM_PIXELS;
			if (d <= cfg_red) begin
				r = COL_FULL;
				g = COL_OFF;
			end else if (d <= cfg_orange) begin
				r = COL_FULL;
				g = COL_HALF;
			end else begin
				r = COL_OFF;
				g = COL_FULL;
			end
			flash_on = 1'b0;
		end
	endfunction

	task automatic send_sample(input logic [DIST_W-1:0] d, input bit typed, input int tlit,
			input logic [7:0] tred);
		int lit;
		logic [7:0] r;
		logic [7:0] g;
		pixel_t p;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			distance_mm <= 16'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance_mm <= d;
		do @(posedge clk); while (in_stall);
		predict_frame(d, lit, r, g);
		if (typed) begin
			lit = tlit;
			r = tred;
			g = COL_OFF;
		end
		for (int i = 0; i < NUM_PIXELS; i++) begin
			p.idx = PIX_W'(i);
			p.red = (i < lit) ? r : COL_OFF;
			p.green = (i < lit) ? g : COL_OFF;
			p.blue = COL_OFF;
			p.last = (i == NUM_PIXELS - 1);
			expected_pixels.push_back(p);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIST_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read back the same register
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[DIST_W-1:0] !== val) begin
			$display("%0t: register %0d readback: expected %0d, got %0d", $time, idx, val,
				prdata[DIST_W-1:0]);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [DIST_W-1:0] mx, input logic [DIST_W-1:0] st,
			input logic [DIST_W-1:0] og, input logic [DIST_W-1:0] rd);
		write_reg(REG_MAX, mx);
		write_reg(REG_STOP, st);
		write_reg(REG_ORANGE, og);
		write_reg(REG_RED, rd);
		cfg_max = mx;
		cfg_stop = st;
		cfg_orange = og;
		cfg_red = rd;
	endtask

	task automatic drain_frames();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// bias toward the flash range, the bar range and the thresholds
	function automatic logic [DIST_W-1:0] pick_distance();
		int stop_i;
		int max_i;
		int t;
		int v;
		stop_i = cfg_stop;
		max_i = cfg_max;
		case ($urandom_range(0, 9))
			0: begin
				v = $urandom_range(0, 65535);
			end
			1, 2: begin
				v = $urandom_range(0, stop_i);
			end
			8, 9: begin
				case ($urandom_range(0, 3))
					0: t = max_i;
					1: t = stop_i;
					2: t = cfg_orange;
					default: t = cfg_red;
				endcase
				v = t + int'($urandom_range(0, 2)) - 1;
			end
			default: begin
				if (max_i > stop_i + 1)
					v = $urandom_range(stop_i + 1, max_i - 1);
				else
					v = $urandom_range(0, 65535);
			end
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return DIST_W'(v);
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			seen_pixel = '{pixel_index, pixel_red, pixel_green, pixel_blue, last_pixel};
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel: expected none, ", $time,
					"got idx %0d rgb %0d/%0d/%0d last %0b",
					seen_pixel.idx, seen_pixel.red, seen_pixel.green, seen_pixel.blue,
					seen_pixel.last);
				mismatch_count++;
			end else begin
				want_pixel = expected_pixels.pop_front();
				if (seen_pixel !== want_pixel) begin
					$display("%0t: pixel mismatch: ", $time,
						"expected idx %0d rgb %0d/%0d/%0d last %0b, ",
						want_pixel.idx, want_pixel.red, want_pixel.green,
						want_pixel.blue, want_pixel.last,
						"got idx %0d rgb %0d/%0d/%0d last %0b",
						seen_pixel.idx, seen_pixel.red, seen_pixel.green,
						seen_pixel.blue, seen_pixel.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int st;
		int mx;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].mm, directed_rows[i].typed,
				directed_rows[i].lit, directed_rows[i].red);

		for (int blk = 0; blk < 13; blk++) begin
			drain_frames();
			case (blk)
				0: ;
				1: set_thresholds(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
				2: set_thresholds(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
				3: set_thresholds(16'h0000, 16'h0000, 16'h0000, 16'h0000);
				4: set_thresholds(16'd500, 16'd1000, 16'd2000, 16'd800);
				5: set_thresholds(16'd1002, 16'd1000, 16'd1001, 16'd1000);
				default: begin
					st = $urandom_range(0, 4000);
					mx = st + $urandom_range(1, 6000);
					set_thresholds(DIST_W'(mx), DIST_W'(st),
						DIST_W'($urandom_range(st, mx)), DIST_W'($urandom_range(st, mx)));
				end
			endcase
			case (blk % 4)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct = 81;
					out_stall_pct = 0;
				end
				2: begin
					in_idle_pct = 0;
					out_stall_pct = 81;
				end
				default: begin
					in_idle_pct = 18;
					out_stall_pct = 18;
				end
			endcase
			repeat (20)
				send_sample(pick_distance(), 1'b0, 0, COL_OFF);
		end

		drain_frames();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
